@@ src/http2_stream_state_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker assertion macros
// Shared concurrent assertion forms for the stream state tracker.
// ----------------------------------------------------------------------------
`ifndef HTTP2_STREAM_STATE_TRACKER_ASSERT_SVH
`define HTTP2_STREAM_STATE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSST_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSST_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hsst_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker package
// State and outcome types, table codes and the fixed transition table.
// ----------------------------------------------------------------------------
package hsst_pkg;

  // Stream states in their encoded order.
  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_RSV_LOCAL   = 3'd1,
    ST_RSV_REMOTE  = 3'd2,
    ST_OPEN        = 3'd3,
    ST_HC_LOCAL    = 3'd4,
    ST_HC_REMOTE   = 3'd5,
    ST_CLOSED      = 3'd6
  } state_t;

  // Result outcome codes.
  typedef enum logic [2:0] {
    OUT_MOVED      = 3'd0,
    OUT_IGNORED    = 3'd1,
    OUT_SNH        = 3'd2,
    OUT_PROTO_ERR  = 3'd3,
    OUT_CLOSED_ERR = 3'd4
  } outcome_t;

  // Item function codes.
  typedef enum logic {
    FN_EVENT = 1'b0,
    FN_CHECK = 1'b1
  } func_t;

  // Table entry codes: real states first, then the other outcomes.
  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_RL   = 4'd1;
  localparam logic [3:0] T_RR   = 4'd2;
  localparam logic [3:0] T_OPEN = 4'd3;
  localparam logic [3:0] T_HCL  = 4'd4;
  localparam logic [3:0] T_HCR  = 4'd5;
  localparam logic [3:0] T_CLS  = 4'd6;
  localparam logic [3:0] T_IGN  = 4'd7;
  localparam logic [3:0] T_SNH  = 4'd8;
  localparam logic [3:0] T_PER  = 4'd9;
  localparam logic [3:0] T_SCE  = 4'd10;

  // Offset from an outcome table code to its outcome code.
  localparam logic [3:0] T_OUT_OFFSET = 4'd6;

  // Frame type bytes.
  localparam logic [7:0] FT_HEADERS       = 8'd1;
  localparam logic [7:0] FT_PRIORITY      = 8'd2;
  localparam logic [7:0] FT_RST_STREAM    = 8'd3;
  localparam logic [7:0] FT_PUSH_PROMISE  = 8'd5;
  localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;

  // Transition table, rows by state code, columns by event code. The spare
  // row for the unused state code behaves as closed.
  typedef logic [3:0] tab_row_t [8];
  localparam tab_row_t TRANS_TAB [8] = '{
    '{T_SNH, T_OPEN, T_IGN, T_IGN, T_IGN, T_PER, T_RL,  T_PER},
    '{T_HCL, T_PER,  T_IGN, T_IGN, T_CLS, T_CLS, T_SNH, T_PER},
    '{T_SNH, T_HCL,  T_IGN, T_IGN, T_CLS, T_CLS, T_SNH, T_PER},
    '{T_IGN, T_IGN,  T_HCL, T_HCR, T_CLS, T_CLS, T_IGN, T_IGN},
    '{T_SNH, T_IGN,  T_IGN, T_CLS, T_CLS, T_CLS, T_SNH, T_IGN},
    '{T_IGN, T_SCE,  T_CLS, T_IGN, T_CLS, T_CLS, T_IGN, T_SCE},
    '{T_SNH, T_SCE,  T_IGN, T_IGN, T_SNH, T_SCE, T_SNH, T_SCE},
    '{T_SNH, T_SCE,  T_IGN, T_IGN, T_SNH, T_SCE, T_SNH, T_SCE}
  };

  // Result of one item, as held in the result register.
  typedef struct packed {
    outcome_t outcome;
    logic     notify;
    state_t   stream_state;
    logic     send_allowed;
  } result_t;

endpackage

@@ src/hsst_in_if.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker input channel
// Valid/ready channel carrying one event or check item.
// ----------------------------------------------------------------------------
interface hsst_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] event_code;
  logic [7:0] frame_type;

  modport source (output valid, output func, output event_code,
                  output frame_type, input ready);
  modport sink   (input valid, input func, input event_code,
                  input frame_type, output ready);
endinterface

@@ src/hsst_out_if.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface hsst_out_if import hsst_pkg::*; ();
  logic     valid;
  logic     ready;
  outcome_t outcome;
  logic     notify;
  state_t   stream_state;
  logic     send_allowed;

  modport source (output valid, output outcome, output notify,
                  output stream_state, output send_allowed, input ready);
  modport sink   (input valid, input outcome, input notify,
                  input stream_state, input send_allowed, output ready);
endinterface

@@ src/hsst_lookup.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker lookup
// Applies the transition table or the send check to one registered item.
// ----------------------------------------------------------------------------
module hsst_lookup import hsst_pkg::*; (
  input  state_t     cur_state,
  input  logic       func,
  input  logic [2:0] event_code,
  input  logic [7:0] frame_type,
  output state_t     state_nxt,
  output result_t    result
);

  logic [3:0] tab_code;
  logic       is_move;
  logic       allowed;

  // Table entry for the current state and event.
  assign tab_code = TRANS_TAB[cur_state][event_code];
  assign is_move  = (func == FN_EVENT) && (tab_code <= T_CLS);

  // Next state: only an event that lands on a real state moves the stream.
  always_comb begin
    if (is_move) begin
      state_nxt = state_t'(tab_code[2:0]);
    end else begin
      state_nxt = cur_state;
    end
  end

  // Frame types that may be sent in each state.
  always_comb begin
    case (cur_state)
      ST_IDLE: begin
        allowed = (frame_type == FT_PUSH_PROMISE);
      end
      ST_RSV_LOCAL: begin
        allowed = (frame_type == FT_HEADERS) || (frame_type == FT_RST_STREAM) ||
                  (frame_type == FT_PRIORITY);
      end
      ST_RSV_REMOTE, ST_HC_LOCAL: begin
        allowed = (frame_type == FT_RST_STREAM) ||
                  (frame_type == FT_WINDOW_UPDATE) ||
                  (frame_type == FT_PRIORITY);
      end
      ST_OPEN, ST_HC_REMOTE: begin
        allowed = 1'b1;
      end
      default: begin
        allowed = (frame_type == FT_PRIORITY);
      end
    endcase
  end

  // Result fields for the item.
  always_comb begin
    result.stream_state = state_nxt;
    if (func == FN_CHECK) begin
      result.outcome      = OUT_IGNORED;
      result.notify       = 1'b0;
      result.send_allowed = allowed;
    end else begin
      if (is_move) begin
        result.outcome = OUT_MOVED;
      end else begin
        result.outcome = outcome_t'(3'(tab_code - T_OUT_OFFSET));
      end
      result.notify       = (tab_code != T_IGN);
      result.send_allowed = 1'b0;
    end
  end

endmodule

@@ src/http2_stream_state_tracker.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker
// Keeps the state of one HTTP/2 stream, applies stream events and answers
// send checks, one result per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                        Handshake
//  in_chan   sink       func, event_code, frame_type                   valid/ready
//  out_chan  source     outcome, notify, stream_state, send_allowed    valid/ready
//
//  An item is registered on acceptance, and its result is registered in the result
//  register as the item moves on; one item can be taken every cycle while results drain.
//  The single table lookup plus the state register set that rate.
//  Reset returns the stream to idle and empties both registers.
//  A stalled result holds its register; the input register still takes one
//  more item, and input ready drops only when both registers are full.
// ----------------------------------------------------------------------------
`include "http2_stream_state_tracker_assert.svh"

module http2_stream_state_tracker import hsst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hsst_in_if.sink    in_chan,
  hsst_out_if.source out_chan
);

  logic       inp_valid_r;
  logic       func_r;
  logic [2:0] event_code_r;
  logic [7:0] frame_type_r;
  logic       res_valid_r;
  result_t    res_r;
  state_t     state_r;
  state_t     state_nxt;
  result_t    res_nxt;
  logic       advance;

  // The registered item moves on when the result register is free or draining.
  assign advance       = inp_valid_r && (!res_valid_r || out_chan.ready);
  assign in_chan.ready = !inp_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      inp_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      func_r       <= in_chan.func;
      event_code_r <= in_chan.event_code;
      frame_type_r <= in_chan.frame_type;
    end
  end

  // Table lookup and send check.
  hsst_lookup u_lookup (
    .cur_state  (state_r),
    .func       (func_r),
    .event_code (event_code_r),
    .frame_type (frame_type_r),
    .state_nxt  (state_nxt),
    .result     (res_nxt)
  );

  // Stream state register, updated as each item moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = res_valid_r;
  assign out_chan.outcome      = res_r.outcome;
  assign out_chan.notify       = res_r.notify;
  assign out_chan.stream_state = res_r.stream_state;
  assign out_chan.send_allowed = res_r.send_allowed;

  // A check transaction never changes the stream state.
  `HSST_ASSERT_NXT(a_check_keeps_state, clk, rst_n, advance && (func_r == FN_CHECK), $stable(state_r), "check item changed the stream state")

  // A move leaves the stored state equal to the reported state.
  `HSST_ASSERT_NXT(a_move_updates_state, clk, rst_n, advance && (res_nxt.outcome == OUT_MOVED), state_r == res_r.stream_state, "moved result disagrees with stored state")

  // A permitted send is only ever reported by a silent check result.
  `HSST_ASSERT_IMP(a_allowed_is_check, clk, rst_n, res_valid_r && res_r.send_allowed, (res_r.outcome == OUT_IGNORED) && !res_r.notify, "send_allowed set on an event result")

endmodule

@@ tb/tb_http2_stream_state_tracker.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state tracker testbench
// Sends event and check items through the valid/ready input channel. A local
// model of the stream state machine predicts every result, and each result
// transaction is compared field by field with the oldest prediction. A short
// directed table runs first, then a random walk through the stream states,
// with random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_http2_stream_state_tracker import hsst_pkg::*; ();

  // Event codes as carried on the input channel.
  localparam logic [2:0] EV_SEND_HEADERS = 3'd0;
  localparam logic [2:0] EV_RECV_HEADERS = 3'd1;
  localparam logic [2:0] EV_SEND_END     = 3'd2;
  localparam logic [2:0] EV_RECV_END     = 3'd3;
  localparam logic [2:0] EV_SEND_RST     = 3'd4;
  localparam logic [2:0] EV_RECV_RST     = 3'd5;
  localparam logic [2:0] EV_SEND_PUSH    = 3'd6;
  localparam logic [2:0] EV_RECV_PUSH    = 3'd7;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1635;
  localparam int MAX_GAP       = 16;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 1000;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    func_t      fn;
    logic [2:0] ev;
    logic [7:0] ft;
    logic       typed;
    result_t    want;
  } dir_row_t;

  // The directed rows all stay in idle, so the random walk starts from there.
  localparam int DIR_ROWS = 15;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{FN_CHECK, EV_SEND_HEADERS, FT_PUSH_PROMISE,  1'b1,
      '{OUT_IGNORED,   1'b0, ST_IDLE, 1'b1}},
    '{FN_CHECK, EV_RECV_PUSH,    8'h00,            1'b1,
      '{OUT_IGNORED,   1'b0, ST_IDLE, 1'b0}},
    '{FN_CHECK, EV_SEND_HEADERS, 8'hFF,            1'b1,
      '{OUT_IGNORED,   1'b0, ST_IDLE, 1'b0}},
    '{FN_CHECK, EV_SEND_HEADERS, FT_HEADERS,       1'b0, '0},
    '{FN_CHECK, EV_SEND_HEADERS, FT_PRIORITY,      1'b0, '0},
    '{FN_CHECK, EV_SEND_HEADERS, FT_RST_STREAM,    1'b0, '0},
    '{FN_CHECK, EV_SEND_HEADERS, FT_WINDOW_UPDATE, 1'b0, '0},
    '{FN_CHECK, EV_RECV_PUSH,    8'h80,            1'b0, '0},
    '{FN_CHECK, EV_RECV_PUSH,    8'h7F,            1'b0, '0},
    '{FN_EVENT, EV_SEND_HEADERS, 8'h00,            1'b1,
      '{OUT_SNH,       1'b1, ST_IDLE, 1'b0}},
    '{FN_EVENT, EV_RECV_RST,     8'hFF,            1'b1,
      '{OUT_PROTO_ERR, 1'b1, ST_IDLE, 1'b0}},
    '{FN_EVENT, EV_RECV_PUSH,    8'h00,            1'b1,
      '{OUT_PROTO_ERR, 1'b1, ST_IDLE, 1'b0}},
    '{FN_EVENT, EV_SEND_END,     8'hFF,            1'b0, '0},
    '{FN_EVENT, EV_RECV_END,     8'h00,            1'b0, '0},
    '{FN_EVENT, EV_SEND_RST,     8'hFF,            1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  hsst_in_if  in_chan ();
  hsst_out_if out_chan ();

  http2_stream_state_tracker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Stream state as the model sees it after every accepted item.
  state_t  tracked_state = ST_IDLE;
  result_t pending_results [$];
  int      fail_count    = 0;
  int      items_sent    = 0;
  int      results_seen  = 0;
  int      quiet_cycles  = 0;
  bit      send_steady   = 1'b0;
  bit      take_steady   = 1'b0;

  always #5 clk = ~clk;

  // Result of one item applied to the stream in state st. For events the
  // stream_state field carries the state after the step.
  function automatic result_t predict_stream_step(state_t st, func_t fn,
                                                  logic [2:0] ev, logic [7:0] ft);
    result_t  r;
    outcome_t oc;
    state_t   nxt;
    r.outcome      = OUT_IGNORED;
    r.notify       = 1'b0;
    r.stream_state = st;
    r.send_allowed = 1'b0;
    if (fn == FN_CHECK) begin
      case (st)
        ST_IDLE:      r.send_allowed = (ft == FT_PUSH_PROMISE);
        ST_RSV_LOCAL: r.send_allowed = (ft == FT_HEADERS) || (ft == FT_RST_STREAM) ||
                                       (ft == FT_PRIORITY);
        ST_RSV_REMOTE, ST_HC_LOCAL:
          r.send_allowed = (ft == FT_RST_STREAM) || (ft == FT_WINDOW_UPDATE) ||
                           (ft == FT_PRIORITY);
        ST_OPEN, ST_HC_REMOTE: r.send_allowed = 1'b1;
        default:      r.send_allowed = (ft == FT_PRIORITY);
      endcase
    end else begin
      oc  = OUT_MOVED;
      nxt = st;
      case (st)
        ST_IDLE: begin
          case (ev)
            EV_SEND_HEADERS:           oc  = OUT_SNH;
            EV_RECV_HEADERS:           nxt = ST_OPEN;
            EV_RECV_RST, EV_RECV_PUSH: oc  = OUT_PROTO_ERR;
            EV_SEND_PUSH:              nxt = ST_RSV_LOCAL;
            default:                   oc  = OUT_IGNORED;
          endcase
        end
        ST_RSV_LOCAL: begin
          case (ev)
            EV_SEND_HEADERS:               nxt = ST_HC_LOCAL;
            EV_RECV_HEADERS, EV_RECV_PUSH: oc  = OUT_PROTO_ERR;
            EV_SEND_RST, EV_RECV_RST:      nxt = ST_CLOSED;
            EV_SEND_PUSH:                  oc  = OUT_SNH;
            default:                       oc  = OUT_IGNORED;
          endcase
        end
        ST_RSV_REMOTE: begin
          case (ev)
            EV_SEND_HEADERS, EV_SEND_PUSH: oc  = OUT_SNH;
            EV_RECV_HEADERS:               nxt = ST_HC_LOCAL;
            EV_SEND_RST, EV_RECV_RST:      nxt = ST_CLOSED;
            EV_RECV_PUSH:                  oc  = OUT_PROTO_ERR;
            default:                       oc  = OUT_IGNORED;
          endcase
        end
        ST_OPEN: begin
          case (ev)
            EV_SEND_END:              nxt = ST_HC_LOCAL;
            EV_RECV_END:              nxt = ST_HC_REMOTE;
            EV_SEND_RST, EV_RECV_RST: nxt = ST_CLOSED;
            default:                  oc  = OUT_IGNORED;
          endcase
        end
        ST_HC_LOCAL: begin
          case (ev)
            EV_SEND_HEADERS, EV_SEND_PUSH:          oc  = OUT_SNH;
            EV_RECV_END, EV_SEND_RST, EV_RECV_RST:  nxt = ST_CLOSED;
            default:                                oc  = OUT_IGNORED;
          endcase
        end
        ST_HC_REMOTE: begin
          case (ev)
            EV_RECV_HEADERS, EV_RECV_PUSH:          oc  = OUT_CLOSED_ERR;
            EV_SEND_END, EV_SEND_RST, EV_RECV_RST:  nxt = ST_CLOSED;
            default:                                oc  = OUT_IGNORED;
          endcase
        end
        // Closed, and the unused code that behaves like it.
        default: begin
          case (ev)
            EV_SEND_HEADERS, EV_SEND_RST, EV_SEND_PUSH: oc = OUT_SNH;
            EV_RECV_HEADERS, EV_RECV_RST, EV_RECV_PUSH: oc = OUT_CLOSED_ERR;
            default:                                    oc = OUT_IGNORED;
          endcase
        end
      endcase
      r.outcome = oc;
      r.notify  = (oc != OUT_IGNORED);
      if (oc == OUT_MOVED) begin
        r.stream_state = nxt;
      end
    end
    return r;
  endfunction

  // Picks an event that either moves the stream or leaves it where it is.
  // Closed has no moving event, so a random code is used there.
  function automatic logic [2:0] pick_event(state_t st, bit want_move);
    logic [2:0] cands [$];
    result_t    r;
    for (int e = 0; e < 8; e++) begin
      r = predict_stream_step(st, FN_EVENT, 3'(e), 8'h00);
      if ((r.outcome == OUT_MOVED) == want_move) begin
        cands.push_back(3'(e));
      end
    end
    if (cands.size() == 0) begin
      return 3'($urandom_range(0, 7));
    end
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Offers one item after a random gap and records its expected result once
  // the transaction has been accepted.
  task automatic offer_item(func_t fn, logic [2:0] ev, logic [7:0] ft,
                            logic typed, result_t want);
    int      gap;
    result_t r;
    if (items_sent % 100 == 0) begin
      send_steady = ($urandom_range(0, 2) == 0);
    end
    gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.func       <= fn;
    in_chan.event_code <= ev;
    in_chan.frame_type <= ft;
    do @(posedge clk); while (!in_chan.ready);
    r = predict_stream_step(tracked_state, fn, ev, ft);
    tracked_state = r.stream_state;
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  // Stimulus: reset, directed table, random walk, then drain.
  initial begin
    func_t      fn;
    logic [2:0] ev;
    logic [7:0] ft;
    int         roll;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.func       <= FN_EVENT;
    in_chan.event_code <= EV_SEND_HEADERS;
    in_chan.frame_type <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      offer_item(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].ev, DIRECTED_ROWS[i].ft,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // Moves are rare so that the walk lingers in each state it reaches
    // before the stream finally closes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 299);
      fn   = FN_EVENT;
      ev   = 3'($urandom_range(0, 7));
      ft   = 8'($urandom);
      if (roll == 0) begin
        ev = pick_event(tracked_state, 1'b1);
      end else if (roll < 150) begin
        fn = FN_CHECK;
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 6))
            0: ft = FT_HEADERS;
            1: ft = FT_PRIORITY;
            2: ft = FT_RST_STREAM;
            3: ft = FT_PUSH_PROMISE;
            4: ft = FT_WINDOW_UPDATE;
            5: ft = 8'h00;
            default: ft = 8'hFF;
          endcase
        end
      end else if (roll > 1) begin
        ev = pick_event(tracked_state, 1'b0);
      end
      offer_item(fn, ev, ft, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and the field checks.
  initial begin
    int      stall;
    result_t got;
    result_t want;
    out_chan.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen % 100 == 0) begin
        take_steady = ($urandom_range(0, 2) == 0);
      end
      stall = take_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (results_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.outcome      = out_chan.outcome;
      got.notify       = out_chan.notify;
      got.stream_state = out_chan.stream_state;
      got.send_allowed = out_chan.send_allowed;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, outcome %0d state %0d", $time,
                 got.outcome, got.stream_state);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d, actual %0d", $time,
                   want.outcome, got.outcome);
          fail_count++;
        end
        if (got.notify !== want.notify) begin
          $display("%0t: notify expected %0d, actual %0d", $time,
                   want.notify, got.notify);
          fail_count++;
        end
        if (got.stream_state !== want.stream_state) begin
          $display("%0t: stream_state expected %0d, actual %0d", $time,
                   want.stream_state, got.stream_state);
          fail_count++;
        end
        if (got.send_allowed !== want.send_allowed) begin
          $display("%0t: send_allowed expected %0d, actual %0d", $time,
                   want.send_allowed, got.send_allowed);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run once no transaction has happened for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

endmodule
